@@ src/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants for the projected Coulomb field block: register indexes,
// field widths, reset values and the fixed unit factor.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MID_X       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_Y       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_Z       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_X      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_Y      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_Z      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_LENGTH = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIELECTRIC  = 4'd7;

  // Payload widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned CHG_W  = 16;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned DIEL_W = 16;
  localparam int unsigned RES_W  = 48;

  // Reset values of the registers that do not reset to zero
  localparam logic [POS_W-1:0]  BOND_Z_RST      = 32'd65536;
  localparam logic [LEN_W-1:0]  BOND_LENGTH_RST = 31'd65536;
  localparam logic [DIEL_W-1:0] DIELECTRIC_RST  = 16'd256;

  // kT per e unit factor at 298 K, Q.16
  localparam int unsigned       CFAC_W   = 26;
  localparam logic [CFAC_W-1:0] CFAC_Q16 = 26'd36748749;

  // Largest result magnitude, 2^47 - 1
  localparam logic [RES_W-2:0] RES_MAX = '1;

endpackage

@@ src/coulomb_field_projection_top.sv @@
// ----------------------------------------------------------------------------
// coulomb_field_projection_top
// Sums the Coulomb field of a stream of point charges at a midpoint and
// projects it on a bond vector, scaled to kT per e per Angstrom.
// ----------------------------------------------------------------------------
// A charge beat is taken only while the block is idle. Each charge runs
// through bit-serial units in turn: shift-add for the squared offsets and
// charge products, a two-bit-per-step square root, shift-add for r^3, and
// restoring division (three lanes, one per axis), plus setup and
// accumulation steps before the block is ready again. A charge that sits
// exactly on the midpoint is skipped and flagged. The beat marked last then
// adds the projection: bond products, division by the bond length,
// multiplication by the unit factor and division by the dielectric. The
// result sits in an output register, so the next charge is taken while the
// result still waits for out_ready.
// Configuration writes take effect at once and are meant for idle periods.

module coulomb_field_projection_top (
  input  logic                                clk,
  input  logic                                rst,
  // charge channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cfp_pkg::POS_W-1:0]    pos_x,
  input  logic signed [cfp_pkg::POS_W-1:0]    pos_y,
  input  logic signed [cfp_pkg::POS_W-1:0]    pos_z,
  input  logic signed [cfp_pkg::CHG_W-1:0]    charge,
  input  logic                                last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cfp_pkg::RES_W-1:0]    projected_field,
  output logic                                zero_distance,
  output logic                                saturated,
  // configuration
  input  logic                                cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_DEN,
    S_DPREP,
    S_DIV,
    S_ACC,
    S_FIN,
    S_MULB,
    S_SUM,
    S_ABS,
    S_DIVL,
    S_MULC,
    S_DIVD,
    S_OUT
  } state_t;

  state_t state;
  logic [6:0] cnt;

  // configuration registers
  logic signed [31:0] mid  [3];
  logic signed [31:0] bond [3];
  logic [cfp_pkg::LEN_W-1:0]  bond_length;
  logic [cfp_pkg::DIEL_W-1:0] dielectric;

  // set state
  logic signed [63:0] accum [3];
  logic zero_seen;
  logic sat_seen;

  // per-charge operands
  logic        a_neg [3];
  logic [15:0] qm;
  logic        q_neg;
  logic        is_last;

  // squares and charge products
  logic [35:0] sq_mb [3];
  logic [71:0] sq_ma [3];
  logic [51:0] sq_qa [3];
  logic [71:0] sq    [3];
  logic [51:0] qmm   [3];

  // square root
  logic [73:0]  r2;
  logic [73:0]  rad;
  logic [38:0]  sq_rem;
  logic [36:0]  root;

  // r^3
  logic [110:0] den;
  logic [110:0] den_ma;
  logic [36:0]  den_rb;

  // per-axis division
  logic [110:0] div_rem  [3];
  logic [62:0]  div_bits [3];
  logic [62:0]  div_q    [3];
  logic         div_sat  [3];

  // projection
  logic [95:0]  mb_ash [3];
  logic [31:0]  mb_b [3];
  logic [95:0]  mb_t [3];
  logic         mb_neg [3];
  logic [97:0]  sum_s;
  logic         res_neg;
  logic [96:0]  ldiv_bits;
  logic [30:0]  ldiv_rem;
  logic [96:0]  p_quo;
  logic [122:0] mc_acc;
  logic [122:0] mc_p;
  logic [cfp_pkg::CFAC_W-1:0] mc_k;
  logic [98:0]  ddiv_bits;
  logic [15:0]  ddiv_rem;
  logic [46:0]  ddiv_q;
  logic         ddiv_ovf;

  // ---------------- accept path: offsets in Angstrom ----------------
  logic signed [31:0] pos_arr [3];
  logic signed [32:0] diff    [3];
  logic signed [36:0] scaled  [3];
  logic signed [36:0] scaled_n[3];
  logic [35:0]        in_mag  [3];
  logic               in_zero;
  logic [15:0]        chg_mag;
  logic [15:0]        chg_n;

  assign pos_arr[0] = pos_x;
  assign pos_arr[1] = pos_y;
  assign pos_arr[2] = pos_z;

  always_comb begin
    in_zero = 1'b1;
    for (int j = 0; j < 3; j++) begin
      diff[j]     = 33'(mid[j]) - 33'(pos_arr[j]);
      // times ten as 8x + 2x
      scaled[j]   = (37'(diff[j]) <<< 3) + (37'(diff[j]) <<< 1);
      scaled_n[j] = -scaled[j];
      in_mag[j]   = scaled[j][36] ? scaled_n[j][35:0] : scaled[j][35:0];
      if (diff[j] != 33'sd0) begin
        in_zero = 1'b0;
      end
    end
    chg_n   = 16'(-charge);
    chg_mag = charge[15] ? chg_n : charge;
  end

  // ---------------- square root step (two bits per cycle) ----------------
  logic [38:0] sqrt_sh;
  logic [38:0] sqrt_trial;
  logic        sqrt_ge;

  always_comb begin
    sqrt_sh    = {sq_rem[36:0], rad[73:72]};
    sqrt_trial = {root, 2'b01};
    sqrt_ge    = sqrt_sh >= sqrt_trial;
  end

  // ---------------- per-axis lanes ----------------
  logic [110:0] h_ext    [3];
  logic [111:0] div_tr   [3];
  logic [111:0] div_df   [3];
  logic         div_ge   [3];
  logic [62:0]  c_mag    [3];
  logic [64:0]  c_sgn    [3];
  logic [64:0]  acc_sum  [3];
  logic [63:0]  acc_new  [3];
  logic         acc_ovf  [3];
  logic [63:0]  acc_mag  [3];
  logic [31:0]  bond_mag [3];
  logic [97:0]  t_sgn    [3];
  logic [97:0]  s_total;
  logic [97:0]  s_abs;

  always_comb begin
    s_total = '0;
    for (int j = 0; j < 3; j++) begin
      h_ext[j]   = {70'd0, qmm[j][51:11]};
      div_tr[j]  = {div_rem[j], div_bits[j][62]};
      div_df[j]  = div_tr[j] - {1'b0, den};
      div_ge[j]  = div_tr[j] >= {1'b0, den};
      // clip the contribution, then apply the sign of charge times offset
      c_mag[j]   = div_sat[j] ? {63{1'b1}} : div_q[j];
      c_sgn[j]   = (q_neg != a_neg[j]) ? -{2'b00, c_mag[j]} : {2'b00, c_mag[j]};
      acc_sum[j] = {accum[j][63], accum[j]} + c_sgn[j];
      acc_ovf[j] = acc_sum[j][64] ^ acc_sum[j][63];
      if (acc_ovf[j]) begin
        acc_new[j] = acc_sum[j][64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        acc_new[j] = acc_sum[j][63:0];
      end
      acc_mag[j]  = accum[j][63] ? 64'(-accum[j]) : accum[j];
      bond_mag[j] = bond[j][31] ? 32'(-bond[j]) : bond[j];
      t_sgn[j]    = mb_neg[j] ? -{2'b00, mb_t[j]} : {2'b00, mb_t[j]};
      s_total     = s_total + t_sgn[j];
    end
    s_abs = sum_s[97] ? -sum_s : sum_s;
  end

  // ---------------- long divisions of the projection ----------------
  logic [cfp_pkg::LEN_W-1:0]  len_eff;
  logic [cfp_pkg::DIEL_W-1:0] diel_eff;
  logic [31:0] ldiv_tr;
  logic        ldiv_ge;
  logic [31:0] ldiv_df;
  logic [16:0] ddiv_tr;
  logic        ddiv_ge;
  logic [16:0] ddiv_df;
  logic [47:0] res_mag;

  always_comb begin
    // a zero divisor counts as one LSB
    len_eff  = (bond_length == '0) ? 31'd1 : bond_length;
    diel_eff = (dielectric == '0) ? 16'd1 : dielectric;
    ldiv_tr  = {ldiv_rem, ldiv_bits[96]};
    ldiv_ge  = ldiv_tr >= {1'b0, len_eff};
    ldiv_df  = ldiv_tr - {1'b0, len_eff};
    ddiv_tr  = {ddiv_rem, ddiv_bits[98]};
    ddiv_ge  = ddiv_tr >= {1'b0, diel_eff};
    ddiv_df  = ddiv_tr - {1'b0, diel_eff};
    res_mag  = ddiv_ovf ? {1'b0, cfp_pkg::RES_MAX} : {1'b0, ddiv_q};
  end

  assign in_ready = (state == S_IDLE);

  // ---------------- sequencer and datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      out_valid   <= 1'b0;
      zero_seen   <= 1'b0;
      sat_seen    <= 1'b0;
      mid[0]      <= '0;
      mid[1]      <= '0;
      mid[2]      <= '0;
      bond[0]     <= '0;
      bond[1]     <= '0;
      bond[2]     <= cfp_pkg::BOND_Z_RST;
      bond_length <= cfp_pkg::BOND_LENGTH_RST;
      dielectric  <= cfp_pkg::DIELECTRIC_RST;
      for (int j = 0; j < 3; j++) begin
        accum[j] <= '0;
      end
    end else begin
      // drop the result once the beat is taken, unless a new one replaces it
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          cfp_pkg::REG_MID_X:       mid[0]      <= cfg_data;
          cfp_pkg::REG_MID_Y:       mid[1]      <= cfg_data;
          cfp_pkg::REG_MID_Z:       mid[2]      <= cfg_data;
          cfp_pkg::REG_BOND_X:      bond[0]     <= cfg_data;
          cfp_pkg::REG_BOND_Y:      bond[1]     <= cfg_data;
          cfp_pkg::REG_BOND_Z:      bond[2]     <= cfg_data;
          cfp_pkg::REG_BOND_LENGTH: bond_length <= cfg_data[cfp_pkg::LEN_W-1:0];
          cfp_pkg::REG_DIELECTRIC:  dielectric  <= cfg_data[cfp_pkg::DIEL_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_last <= last;
            q_neg   <= charge[15];
            qm      <= chg_mag;
            for (int j = 0; j < 3; j++) begin
              a_neg[j] <= scaled[j][36];
              sq_mb[j] <= in_mag[j];
              sq_ma[j] <= {36'd0, in_mag[j]};
              sq_qa[j] <= {36'd0, chg_mag};
              sq[j]    <= '0;
              qmm[j]   <= '0;
            end
            if (in_zero) begin
              // charge on the midpoint: skip it and flag it
              zero_seen <= 1'b1;
              state     <= last ? S_FIN : S_IDLE;
            end else begin
              cnt   <= 7'd35;
              state <= S_SQ;
            end
          end
        end

        S_SQ: begin
          // shift-add: offset squared and charge times offset together
          for (int j = 0; j < 3; j++) begin
            if (sq_mb[j][0]) begin
              sq[j]  <= sq[j] + sq_ma[j];
              qmm[j] <= qmm[j] + sq_qa[j];
            end
            sq_mb[j] <= sq_mb[j] >> 1;
            sq_ma[j] <= sq_ma[j] << 1;
            sq_qa[j] <= sq_qa[j] << 1;
          end
          if (cnt == 7'd0) begin
            r2     <= 74'(sq[0]) + 74'(sq[1]) + 74'(sq[2]) +
                      (sq_mb[0][0] ? 74'(sq_ma[0]) : 74'd0) +
                      (sq_mb[1][0] ? 74'(sq_ma[1]) : 74'd0) +
                      (sq_mb[2][0] ? 74'(sq_ma[2]) : 74'd0);
            state  <= S_SQRT;
            cnt    <= 7'd37;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_SQRT: begin
          if (cnt == 7'd37) begin
            // load the radicand after r2 has settled
            rad    <= r2;
            sq_rem <= '0;
            root   <= '0;
            cnt    <= 7'd36;
          end else begin
            rad    <= rad << 2;
            sq_rem <= sqrt_ge ? (sqrt_sh - sqrt_trial) : sqrt_sh;
            root   <= {root[35:0], sqrt_ge};
            if (cnt == 7'd0) begin
              den    <= '0;
              den_ma <= {37'd0, r2};
              den_rb <= {root[35:0], sqrt_ge};
              cnt    <= 7'd36;
              state  <= S_DEN;
            end else begin
              cnt <= cnt - 7'd1;
            end
          end
        end

        S_DEN: begin
          if (den_rb[0]) begin
            den <= den + den_ma;
          end
          den_ma <= den_ma << 1;
          den_rb <= den_rb >> 1;
          if (cnt == 7'd0) begin
            state <= S_DPREP;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_DPREP: begin
          // upper dividend bits at or above r^3 mean a quotient past 2^63
          for (int j = 0; j < 3; j++) begin
            div_sat[j]  <= h_ext[j] >= den;
            div_rem[j]  <= h_ext[j];
            div_bits[j] <= {qmm[j][10:0], 52'd0};
            div_q[j]    <= '0;
          end
          cnt   <= 7'd62;
          state <= S_DIV;
        end

        S_DIV: begin
          for (int j = 0; j < 3; j++) begin
            div_rem[j]  <= div_ge[j] ? div_df[j][110:0] : div_tr[j][110:0];
            div_bits[j] <= div_bits[j] << 1;
            div_q[j]    <= {div_q[j][61:0], div_ge[j]};
          end
          if (cnt == 7'd0) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_ACC: begin
          for (int j = 0; j < 3; j++) begin
            accum[j] <= acc_new[j];
          end
          if (div_sat[0] || div_sat[1] || div_sat[2] ||
              acc_ovf[0] || acc_ovf[1] || acc_ovf[2]) begin
            sat_seen <= 1'b1;
          end
          state <= is_last ? S_FIN : S_IDLE;
        end

        S_FIN: begin
          for (int j = 0; j < 3; j++) begin
            mb_ash[j] <= {32'd0, acc_mag[j]};
            mb_b[j]   <= bond_mag[j];
            mb_t[j]   <= '0;
            mb_neg[j] <= accum[j][63] != bond[j][31];
          end
          cnt   <= 7'd31;
          state <= S_MULB;
        end

        S_MULB: begin
          for (int j = 0; j < 3; j++) begin
            if (mb_b[j][0]) begin
              mb_t[j] <= mb_t[j] + mb_ash[j];
            end
            mb_b[j]   <= mb_b[j] >> 1;
            mb_ash[j] <= mb_ash[j] << 1;
          end
          if (cnt == 7'd0) begin
            state <= S_SUM;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_SUM: begin
          sum_s <= s_total;
          state <= S_ABS;
        end

        S_ABS: begin
          res_neg   <= sum_s[97];
          ldiv_bits <= s_abs[96:0];
          ldiv_rem  <= '0;
          p_quo     <= '0;
          cnt       <= 7'd96;
          state     <= S_DIVL;
        end

        S_DIVL: begin
          ldiv_rem  <= ldiv_ge ? ldiv_df[30:0] : ldiv_tr[30:0];
          ldiv_bits <= ldiv_bits << 1;
          p_quo     <= {p_quo[95:0], ldiv_ge};
          if (cnt == 7'd0) begin
            mc_acc <= '0;
            mc_p   <= {26'd0, p_quo[95:0], ldiv_ge};
            mc_k   <= cfp_pkg::CFAC_Q16;
            cnt    <= 7'(cfp_pkg::CFAC_W - 1);
            state  <= S_MULC;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_MULC: begin
          if (mc_k[0]) begin
            mc_acc <= mc_acc + mc_p;
          end
          mc_k <= mc_k >> 1;
          mc_p <= mc_p << 1;
          if (cnt == 7'd0) begin
            state <= S_DIVD;
            cnt   <= 7'd99;
          end else begin
            cnt <= cnt - 7'd1;
          end
        end

        S_DIVD: begin
          if (cnt == 7'd99) begin
            // divide by 2^24 first, then by the dielectric
            ddiv_bits <= mc_acc[122:24];
            ddiv_rem  <= '0;
            ddiv_q    <= '0;
            ddiv_ovf  <= 1'b0;
            cnt       <= 7'd98;
          end else begin
            ddiv_rem  <= ddiv_ge ? ddiv_df[15:0] : ddiv_tr[15:0];
            ddiv_bits <= ddiv_bits << 1;
            ddiv_q    <= {ddiv_q[45:0], ddiv_ge};
            // any quotient bit at or above 2^47 clips the result
            ddiv_ovf  <= ddiv_ovf | ddiv_q[46];
            if (cnt == 7'd0) begin
              state <= S_OUT;
            end else begin
              cnt <= cnt - 7'd1;
            end
          end
        end

        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            projected_field <= res_neg ? -res_mag : res_mag;
            zero_distance   <= zero_seen;
            saturated       <= sat_seen | ddiv_ovf;
            zero_seen       <= 1'b0;
            sat_seen        <= 1'b0;
            for (int j = 0; j < 3; j++) begin
              accum[j] <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/coulomb_field_projection_top_test.sv @@
// ----------------------------------------------------------------------------
// coulomb_field_projection_top_test
// Self-checking bench for the projected Coulomb field block. Charge sets are
// queued by a stimulus process, driven by a clocked driver, and every result
// beat is checked against a bit-exact predictor held in this module.
// ----------------------------------------------------------------------------
module coulomb_field_projection_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  // Worst case from accept of a last beat to an idle block, with margin
  localparam int unsigned SETTLE_CYCLES = 600;

  typedef struct {
    logic signed [cfp_pkg::POS_W-1:0] pos [3];
    logic signed [cfp_pkg::CHG_W-1:0] q;
    logic                             last;
  } charge_beat_t;

  typedef struct {
    logic [cfp_pkg::RES_W-1:0] field;
    logic                      zero_dist;
    logic                      sat;
  } field_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [cfp_pkg::POS_W-1:0] pos_x = '0;
  logic signed [cfp_pkg::POS_W-1:0] pos_y = '0;
  logic signed [cfp_pkg::POS_W-1:0] pos_z = '0;
  logic signed [cfp_pkg::CHG_W-1:0] charge = '0;
  logic                             last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [cfp_pkg::RES_W-1:0] projected_field;
  logic                             zero_distance;
  logic                             saturated;
  logic                             cfg_we = 1'b0;
  logic [cfp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [cfp_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  coulomb_field_projection_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .charge(charge), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .projected_field(projected_field), .zero_distance(zero_distance),
    .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Pending charge beats and the field results they will produce
  charge_beat_t  charge_q [$];
  field_result_t field_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          in_taken = 1'b0;

  // Predictor state: register copies, field accumulator and set flags
  logic signed [cfp_pkg::POS_W-1:0] mid_reg [3];
  logic signed [cfp_pkg::POS_W-1:0] bond_reg [3];
  logic [cfp_pkg::LEN_W-1:0]        len_reg;
  logic [cfp_pkg::DIEL_W-1:0]       diel_reg;
  longint                           fld_acc [3];
  bit                               zero_flag, sat_flag;

  // Midpoint as seen by the stimulus, to place charges close to it
  logic signed [cfp_pkg::POS_W-1:0] gen_mid [3];

  // Fold one accepted charge into the field; on the last beat of a set,
  // project on the bond, scale, clip and queue the expected result.
  task automatic predict_field_beat(input charge_beat_t b);
    longint                    off [3];
    logic [63:0]               mag [3];
    logic [127:0]              r2, den, num, quot, s_mag, p, big, lenw, dielw;
    logic [63:0]               root, cand, cm;
    logic signed [127:0]       s, accw, bw;
    logic [64:0]               sum65;
    longint                    c, qm;
    logic [cfp_pkg::RES_W-1:0] res;
    bit                        neg, clip;
    field_result_t             r;
    r2 = '0;
    for (int j = 0; j < 3; j++) begin
      off[j] = (longint'(mid_reg[j]) - longint'(b.pos[j])) * 10;
      mag[j] = (off[j] < 0) ? 64'(-off[j]) : 64'(off[j]);
      r2 += {64'b0, mag[j]} * {64'b0, mag[j]};
    end
    if (r2 == 0) begin
      zero_flag = 1'b1;
    end else begin
      root = '0;
      for (int k = 63; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        if ({64'b0, cand} * {64'b0, cand} <= r2) root = cand;
      end
      den = r2 * {64'b0, root};
      qm = (b.q < 0) ? -longint'(b.q) : longint'(b.q);
      for (int j = 0; j < 3; j++) begin
        num = ({64'b0, 64'(qm)} * {64'b0, mag[j]}) << 52;
        quot = num / den;
        if (quot > 128'h7FFF_FFFF_FFFF_FFFF) begin
          cm = 64'h7FFF_FFFF_FFFF_FFFF;
          sat_flag = 1'b1;
        end else begin
          cm = quot[63:0];
        end
        c = longint'(cm);
        if ((b.q < 0) != (off[j] < 0)) c = -c;
        sum65 = {fld_acc[j][63], fld_acc[j]} + {c[63], c};
        // Clamp the running sum to the 64-bit signed range
        if (sum65[64] != sum65[63]) begin
          sat_flag = 1'b1;
          fld_acc[j] = sum65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          fld_acc[j] = sum65[63:0];
        end
      end
    end
    if (b.last) begin
      s = '0;
      for (int j = 0; j < 3; j++) begin
        accw = fld_acc[j];
        bw = bond_reg[j];
        s += accw * bw;
      end
      neg = (s < 0);
      s_mag = neg ? -s : s;
      // A zero bond length or dielectric counts as one LSB
      lenw = (len_reg == 0) ? 128'd1 : 128'(len_reg);
      dielw = (diel_reg == 0) ? 128'd1 : 128'(diel_reg);
      p = s_mag / lenw;
      big = (p * 128'(cfp_pkg::CFAC_Q16)) / (dielw << 24);
      clip = (big > 128'(cfp_pkg::RES_MAX));
      res = clip ? {1'b0, cfp_pkg::RES_MAX} : big[cfp_pkg::RES_W-1:0];
      if (neg) res = -res;
      r.field = res;
      r.zero_dist = zero_flag;
      r.sat = sat_flag | clip;
      field_q.push_back(r);
      fld_acc = '{0, 0, 0};
      zero_flag = 1'b0;
      sat_flag = 1'b0;
    end
  endtask

  // Monitor: track register writes, predict on accepted charges, check results
  always @(posedge clk) begin
    field_result_t e;
    cycles <= cycles + 1;
    if (rst) begin
      mid_reg = '{0, 0, 0};
      bond_reg = '{0, 0, cfp_pkg::BOND_Z_RST};
      len_reg = cfp_pkg::BOND_LENGTH_RST;
      diel_reg = cfp_pkg::DIELECTRIC_RST;
      fld_acc = '{0, 0, 0};
      zero_flag = 1'b0;
      sat_flag = 1'b0;
      in_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cfp_pkg::REG_MID_X:       mid_reg[0] = cfg_data;
          cfp_pkg::REG_MID_Y:       mid_reg[1] = cfg_data;
          cfp_pkg::REG_MID_Z:       mid_reg[2] = cfg_data;
          cfp_pkg::REG_BOND_X:      bond_reg[0] = cfg_data;
          cfp_pkg::REG_BOND_Y:      bond_reg[1] = cfg_data;
          cfp_pkg::REG_BOND_Z:      bond_reg[2] = cfg_data;
          cfp_pkg::REG_BOND_LENGTH: len_reg = cfg_data[cfp_pkg::LEN_W-1:0];
          cfp_pkg::REG_DIELECTRIC:  diel_reg = cfg_data[cfp_pkg::DIEL_W-1:0];
          default: ;  // drop writes to unmapped indexes
        endcase
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        charge_beat_t b;
        b.pos = '{pos_x, pos_y, pos_z};
        b.q = charge;
        b.last = last;
        predict_field_beat(b);
      end
      if (out_valid && out_ready) begin
        if (field_q.size() == 0) begin
          $error("result beat with no expected result");
          errors++;
        end else begin
          e = field_q.pop_front();
          if (projected_field !== e.field) begin
            $error("projected_field: expected %h, actual %h", e.field, projected_field);
            errors++;
          end
          if (zero_distance !== e.zero_dist) begin
            $error("zero_distance: expected %b, actual %b", e.zero_dist, zero_distance);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated: expected %b, actual %b", e.sat, saturated);
            errors++;
          end
        end
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: hold a beat until taken, then advance or idle; stall the receiver
  always @(negedge clk) begin
    charge_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (charge_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          b = charge_q.pop_front();
          in_valid <= 1'b1;
          pos_x <= b.pos[0];
          pos_y <= b.pos[1];
          pos_z <= b.pos[2];
          charge <= b.q;
          last <= b.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_charge(input logic signed [cfp_pkg::POS_W-1:0] px, py, pz,
                            input logic signed [cfp_pkg::CHG_W-1:0] q, input logic lst);
    charge_beat_t b;
    b.pos = '{px, py, pz};
    b.q = q;
    b.last = lst;
    charge_q.push_back(b);
  endtask

  task automatic write_reg(input logic [cfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= cfp_pkg::REG_MID_Z) gen_mid[idx[1:0]] = val;
  endtask

  // Wait until every queued charge is in and every result is out, then let
  // a trailing charge without a result finish its pass.
  task automatic drain_results();
    @(negedge clk);
    cfg_we <= 1'b0;
    wait (charge_q.size() == 0 && !in_valid && field_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [cfp_pkg::POS_W-1:0] near_mid(input int j);
    int unsigned pick;
    int          span;
    pick = $urandom_range(99);
    if (pick < 3) return gen_mid[j];
    if (pick < 13) return $urandom;
    span = (pick < 55) ? 4096 : 1048576;
    return gen_mid[j] + ($signed($urandom_range(2 * span)) - span);
  endfunction

  initial begin
    int unsigned set_len, sent;
    gen_mid = '{0, 0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets under the reset configuration
    add_charge(32'sh0001_0000, 0, 0, 16'sh1000, 1'b1);
    add_charge(0, 0, 0, 16'sh1000, 1'b1);                     // charge on the midpoint
    add_charge(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000, 1'b0);
    add_charge(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b1);
    add_charge(0, 32'sh0000_8000, 32'shFFFF_0000, 16'sh0000, 1'b1);
    // Max charges one LSB off the midpoint overflow the accumulator and the result
    for (int i = 0; i < 8; i++) add_charge(0, 0, -1, 16'sh7FFF, i == 7);
    for (int i = 0; i < 8; i++) add_charge(0, 0, 1, 16'sh8000, i == 7);
    add_charge(0, 0, 0, 16'sh7FFF, 1'b0);
    add_charge(32'shFFFF_FFFF, 32'sh0000_0001, 32'sh1234_5678, 16'shF000, 1'b0);
    add_charge(32'sh0002_0000, 32'shFFFE_0000, 32'sh0000_0003, 16'sh0800, 1'b1);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      case (ph)
        0: begin
          // Midpoint low, bond high; zero length and dielectric fall back to one LSB
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_MID_X + j), 32'h8000_0000);
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_BOND_X + j), 32'h7FFF_FFFF);
          write_reg(cfp_pkg::REG_BOND_LENGTH, 32'h0);
          write_reg(cfp_pkg::REG_DIELECTRIC, 32'h0);
          write_reg(4'd8, 32'hFFFF_FFFF);
          write_reg(4'd15, 32'h1234_5678);
        end
        1: begin
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_MID_X + j), 32'h7FFF_FFFF);
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_BOND_X + j), 32'h8000_0000);
          write_reg(cfp_pkg::REG_BOND_LENGTH, 32'hFFFF_FFFF);
          write_reg(cfp_pkg::REG_DIELECTRIC, 32'hFFFF_FFFF);
        end
        default: begin
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_MID_X + j), ($urandom_range(3) == 0) ? $urandom
                                      : $signed($urandom_range(20 << 16)) - (10 << 16));
          for (int j = 0; j < 3; j++)
            write_reg(4'(cfp_pkg::REG_BOND_X + j), ($urandom_range(3) == 0) ? $urandom
                                       : $signed($urandom_range(1 << 18)) - (1 << 17));
          write_reg(cfp_pkg::REG_BOND_LENGTH, ($urandom_range(3) == 0) ? $urandom
                                     : $urandom_range(1 << 18, 1));
          write_reg(cfp_pkg::REG_DIELECTRIC, $urandom_range(65535, 256));
        end
      endcase
      drain_results();

      // Sets of one to six charges, mostly near the midpoint
      sent = 0;
      while (sent < 100) begin
        set_len = $urandom_range(6, 1);
        for (int i = 0; i < set_len; i++)
          add_charge(near_mid(0), near_mid(1), near_mid(2), 16'($urandom),
                     i == set_len - 1);
        sent += set_len;
        // In phase 3, pause once mid-phase until the block has returned every result
        if (ph == 3 && sent >= 50 && sent < 50 + set_len) drain_results();
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
